[sv/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants for the RLE / back-reference decoder
// Command encoding passed from the front (parser) to the back (executor).
// ----------------------------------------------------------------------------
package rbd_pkg;

   // command opcodes
   localparam logic [1:0] OP_NOP  = 2'd0;   // no output, may carry a clear
   localparam logic [1:0] OP_FILL = 2'd1;   // one result of len copies of byte
   localparam logic [1:0] OP_COPY = 2'd2;   // len results read from history

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   localparam logic [8:0] SEEN_CAP = 9'd258;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;   // fill value or (distance - 2) for copies
      logic [6:0] len;
      logic       clr;    // end of stream: reset history pointers afterwards
   } cmd_type;

endpackage

[sv/rle_backref_byte_decoder.sv]
// Path: with the back end idle, a literal or fill result passes the command queue, executor
// command register and output register; a copy byte also passes the history read register.
// Throughput: one input byte per cycle, stalled when the 4-entry command queue is full; per
// command the executor pops the queue, writes each literal or fill byte to history with one
// result per fill, and per copied byte reads history, then writes back and emits.
// Reset: synchronous; clears parser, queue, history pointers and output valid, not history.
// ----------------------------------------------------------------------------
// rle_backref_byte_decoder: run-length / back-reference byte stream decoder
// Parser front end, command queue, and history-based executor back end.
// ----------------------------------------------------------------------------
module rle_backref_byte_decoder #(
   parameter int HISTORY_DEPTH = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_code_byte,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_value,
   output logic [6:0] rsp_run_length,
   output logic       rsp_last_of_run
);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_not_empty;
   rbd_pkg::cmd_type push_cmd;
   rbd_pkg::cmd_type head_cmd;

   rbd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_byte (req_code_byte),
      .req_last_in   (req_last_in),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   rbd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   rbd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_cmd           (head_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_run_length  (rsp_run_length),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[sv/rbd_front.sv]
// ----------------------------------------------------------------------------
// rbd_front: compressed byte parser
// Tracks the command phase and turns input bytes into back-end commands.
// ----------------------------------------------------------------------------
module rbd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_code_byte,
   input  logic             req_last_in,
   input  logic             q_full,
   output logic             q_push,
   output rbd_pkg::cmd_type q_cmd
);

   localparam logic [1:0] PH_CODE    = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_FILL    = 2'd2;
   localparam logic [1:0] PH_DIST    = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [6:0] lit_left_ff, lit_left_in;
   logic [6:0] pend_ff, pend_in;
   logic       ended_ff, ended_in;
   logic       accept;
   logic       gen;
   rbd_pkg::cmd_type cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in    = phase_ff;
      lit_left_in = lit_left_ff;
      pend_in     = pend_ff;
      ended_in    = ended_ff;
      gen         = 1'b0;
      cmd.op      = rbd_pkg::OP_NOP;
      cmd.data    = req_code_byte;
      cmd.len     = 7'd1;
      cmd.clr     = req_last_in;
      if (accept) begin
         if (!ended_ff) begin
            case (phase_ff)
               PH_LITERAL: begin
                  gen         = 1'b1;
                  cmd.op      = rbd_pkg::OP_FILL;
                  lit_left_in = lit_left_ff - 7'd1;
                  if (lit_left_ff == 7'd1) begin
                     phase_in = PH_CODE;
                  end
               end
               PH_FILL: begin
                  gen      = 1'b1;
                  cmd.op   = rbd_pkg::OP_FILL;
                  cmd.len  = pend_ff;
                  pend_in  = 7'd0;
                  phase_in = PH_CODE;
               end
               PH_DIST: begin
                  gen      = 1'b1;
                  cmd.op   = rbd_pkg::OP_COPY;
                  cmd.len  = pend_ff;
                  pend_in  = 7'd0;
                  phase_in = PH_CODE;
               end
               default: begin
                  if (req_code_byte < 8'd64) begin
                     lit_left_in = 7'(req_code_byte) + 7'd1;
                     phase_in    = PH_LITERAL;
                  end else if (req_code_byte < 8'd128) begin
                     // zero fill
                     gen      = 1'b1;
                     cmd.op   = rbd_pkg::OP_FILL;
                     cmd.data = 8'd0;
                     cmd.len  = 7'(req_code_byte - 8'd62);
                  end else if (req_code_byte < 8'd192) begin
                     pend_in  = 7'(req_code_byte - 8'd126);
                     phase_in = PH_FILL;
                  end else if (req_code_byte < 8'd254) begin
                     pend_in  = 7'(req_code_byte - 8'd190);
                     phase_in = PH_DIST;
                  end else if (req_code_byte == 8'd255) begin
                     ended_in = 1'b1;
                  end
               end
            endcase
         end
         if (req_last_in) begin
            phase_in    = PH_CODE;
            lit_left_in = 7'd0;
            pend_in     = 7'd0;
            ended_in    = 1'b0;
         end
      end
   end

   // a final byte with no command still goes down as a clear
   assign q_push = accept && (gen || req_last_in);
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CODE;
         lit_left_ff <= 7'd0;
         pend_ff     <= 7'd0;
         ended_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         lit_left_ff <= lit_left_in;
         pend_ff     <= pend_in;
         ended_ff    <= ended_in;
      end
   end

endmodule

[sv/rbd_fifo.sv]
// ----------------------------------------------------------------------------
// rbd_fifo: command queue between parser and executor
// Small register FIFO, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module rbd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output rbd_pkg::cmd_type head_cmd
);

   rbd_pkg::cmd_type entry_ff [rbd_pkg::QDEPTH];
   logic [rbd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rbd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rbd_pkg::QPTR_W:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == (rbd_pkg::QPTR_W+1)'(rbd_pkg::QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("command pushed into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (rbd_pkg::QPTR_W+1)'(rbd_pkg::QDEPTH)) else $error("queue count overrun");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (pop && not_empty && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not drain queue");

endmodule

[sv/rbd_back.sv]
// ----------------------------------------------------------------------------
// rbd_back: command executor with history store
// Writes decoded bytes into the circular history, reads back-references
// and drives the result output register.
// ----------------------------------------------------------------------------
module rbd_back #(
   parameter int HISTORY_DEPTH = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  rbd_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_value,
   output logic [6:0]       rsp_run_length,
   output logic             rsp_last_of_run
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW:0]   DEPTH_C = (AW+1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_AD = AW'(HISTORY_DEPTH - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EMIT  = 3'd1;   // first (only) result of a fill
   localparam logic [2:0] ST_FILLW = 3'd2;   // remaining history writes of a fill
   localparam logic [2:0] ST_RD    = 3'd3;   // history read for a copy byte
   localparam logic [2:0] ST_CPY   = 3'd4;   // emit and write back a copy byte

   logic [7:0] hist_mem [HISTORY_DEPTH];

   logic [2:0]    state_ff, state_in;
   rbd_pkg::cmd_type cmd_ff, cmd_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [8:0]    seen_ff, seen_in;
   logic [7:0]    rd_q_ff;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_value_ff, out_value_in;
   logic [6:0]    out_len_ff, out_len_in;
   logic          out_last_ff, out_last_in;

   logic          slot_free;
   logic          hist_we, hist_re;
   logic [7:0]    hist_wd;
   logic [8:0]    back_dist;
   logic [AW:0]   dist_x, wp_x, rd_sum;
   logic [AW-1:0] rd_addr;
   logic [7:0]    copy_val;
   logic [AW-1:0] wp_next;
   logic [8:0]    seen_next;
   logic          finish;

   assign slot_free = !out_valid_ff || rsp_ready;

   assign back_dist = {1'b0, cmd_ff.data} + 9'd2;
   assign dist_x    = (AW+1)'(back_dist);
   assign wp_x   = {1'b0, wp_ff};
   assign rd_sum = (wp_x >= dist_x) ? wp_x - dist_x : wp_x + DEPTH_C - dist_x;
   assign rd_addr = rd_sum[AW-1:0];

   // sources before stream start read as zero
   assign copy_val  = (back_dist <= seen_ff) ? rd_q_ff : 8'd0;
   assign wp_next   = (wp_ff == LAST_AD) ? '0 : wp_ff + 1'b1;
   assign seen_next = (seen_ff < rbd_pkg::SEEN_CAP) ? seen_ff + 9'd1 : seen_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      q_pop        = 1'b0;
      hist_we      = 1'b0;
      hist_re      = 1'b0;
      hist_wd      = cmd_ff.data;
      finish       = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               cnt_in = q_cmd.len;
               case (q_cmd.op)
                  rbd_pkg::OP_FILL: state_in = ST_EMIT;
                  rbd_pkg::OP_COPY: state_in = ST_RD;
                  default: begin
                     if (q_cmd.clr) begin
                        wp_in   = '0;
                        seen_in = 9'd0;
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_value_in = cmd_ff.data;
               out_len_in   = cnt_ff;
               out_last_in  = 1'b1;
               hist_we      = 1'b1;
               wp_in        = wp_next;
               seen_in      = seen_next;
               cnt_in       = cnt_ff - 7'd1;
               if (cnt_ff == 7'd1) begin
                  finish = 1'b1;
               end else begin
                  state_in = ST_FILLW;
               end
            end
         end
         ST_FILLW: begin
            hist_we = 1'b1;
            wp_in   = wp_next;
            seen_in = seen_next;
            cnt_in  = cnt_ff - 7'd1;
            finish  = (cnt_ff == 7'd1);
         end
         ST_RD: begin
            hist_re  = 1'b1;
            state_in = ST_CPY;
         end
         ST_CPY: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_value_in = copy_val;
               out_len_in   = 7'd1;
               out_last_in  = (cnt_ff == 7'd1);
               hist_we      = 1'b1;
               hist_wd      = copy_val;
               wp_in        = wp_next;
               seen_in      = seen_next;
               cnt_in       = cnt_ff - 7'd1;
               if (cnt_ff == 7'd1) begin
                  finish = 1'b1;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (finish) begin
         state_in = ST_IDLE;
         if (cmd_ff.clr) begin
            wp_in   = '0;
            seen_in = 9'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wp_ff] <= hist_wd;
      end
      if (hist_re) begin
         rd_q_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_len_ff   <= out_len_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         seen_ff      <= 9'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_run_length  = out_len_ff;
   assign rsp_last_of_run = out_last_ff;

   a_seen_cap: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= rbd_pkg::SEEN_CAP) else $error("bytes seen past cap");
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= LAST_AD) else $error("history pointer out of range");
   a_rd_then_cpy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |=> state_ff == ST_CPY) else $error("copy read not followed");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CPY || state_ff == ST_FILLW) |-> cnt_ff != 7'd0)
      else $error("work state with zero count");

endmodule
